// ----- hdl/tacu_pkg.sv -----
`timescale 1ns / 1ps
package tacu_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MSS      = 2'd0;
  localparam logic [1:0] CFG_SSTHRESH = 2'd1;
  localparam logic [1:0] CFG_BUF_SIZE = 2'd2;

  // divider pass lengths
  localparam logic [5:0] DIV_BITS_WIN  = 6'd32;
  localparam logic [5:0] DIV_BITS_RING = 6'd17;

  typedef enum logic [1:0] {
    OPC_ACK   = 2'd0,
    OPC_QUEUE = 2'd1,
    OPC_SEND  = 2'd2,
    OPC_OPEN  = 2'd3
  } opc_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_STALE = 2'd1,
    KIND_SAME  = 2'd2,
    KIND_NEW   = 2'd3
  } ack_kind_t;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_STOP    = 2'd1,
    TMR_RESTART = 2'd2
  } tmr_t;

  // datapath operation of one microstep
  typedef enum logic [3:0] {
    U_NOP,
    U_CLASSIFY,
    U_ACKED,
    U_RING_LOAD,
    U_DIV_STEP,
    U_RING_STORE,
    U_DIV_LOAD_WIN,
    U_ADJ_QUO,
    U_ADJ_MSS,
    U_GROW,
    U_POST,
    U_OTHER,
    U_EMIT
  } uop_t;

  // jump condition of one microstep
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_ACKOP,
    C_NOT_NEW,
    C_DIV_BUSY,
    C_SLOW_START
  } ucond_t;

  typedef struct packed {
    uop_t       op;
    ucond_t     cond;
    logic [3:0] target;
    logic       last;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic        more;
    logic [31:0] quotient;
    logic [16:0] remainder;
  } div_stat_t;

  // microprogram
  function automatic uword_t tacu_ucode(input logic [3:0] step);
    uword_t w;
    w = '{op: U_EMIT, cond: C_NEXT, target: 4'd0, last: 1'b1};
    case (step)
      4'd0:  w = '{op: U_NOP,          cond: C_NOT_ACKOP,  target: 4'd13, last: 1'b0};
      4'd1:  w = '{op: U_CLASSIFY,     cond: C_NEXT,       target: 4'd0,  last: 1'b0};
      4'd2:  w = '{op: U_NOP,          cond: C_NOT_NEW,    target: 4'd12, last: 1'b0};
      4'd3:  w = '{op: U_ACKED,        cond: C_NEXT,       target: 4'd0,  last: 1'b0};
      4'd4:  w = '{op: U_RING_LOAD,    cond: C_NEXT,       target: 4'd0,  last: 1'b0};
      4'd5:  w = '{op: U_DIV_STEP,     cond: C_DIV_BUSY,   target: 4'd5,  last: 1'b0};
      4'd6:  w = '{op: U_RING_STORE,   cond: C_SLOW_START, target: 4'd10, last: 1'b0};
      4'd7:  w = '{op: U_DIV_LOAD_WIN, cond: C_NEXT,       target: 4'd0,  last: 1'b0};
      4'd8:  w = '{op: U_DIV_STEP,     cond: C_DIV_BUSY,   target: 4'd8,  last: 1'b0};
      4'd9:  w = '{op: U_ADJ_QUO,      cond: C_ALWAYS,     target: 4'd11, last: 1'b0};
      4'd10: w = '{op: U_ADJ_MSS,      cond: C_NEXT,       target: 4'd0,  last: 1'b0};
      4'd11: w = '{op: U_GROW,         cond: C_NEXT,       target: 4'd0,  last: 1'b0};
      4'd12: w = '{op: U_POST,         cond: C_ALWAYS,     target: 4'd14, last: 1'b0};
      4'd13: w = '{op: U_OTHER,        cond: C_NEXT,       target: 4'd0,  last: 1'b0};
      default: w = '{op: U_EMIT,       cond: C_NEXT,       target: 4'd0,  last: 1'b1};
    endcase
    return w;
  endfunction

  // a precedes b in sequence space
  function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ----- hdl/tacu_div.sv -----
`timescale 1ns / 1ps
module tacu_div
  import tacu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_ctl_t    ctl,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  input  logic [5:0]  iters,
  output div_stat_t   stat
);

  logic [31:0] dvd_r;
  logic [16:0] dvs_r;
  logic [16:0] rem_r;
  logic [5:0]  cnt_r;
  logic [18:0] trial;
  logic        neg;

  // restoring division, one quotient bit per cycle
  assign trial = {1'b0, rem_r, dvd_r[31]} - {2'b00, dvs_r};
  assign neg   = trial[18];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.load) begin
      cnt_r <= iters;
    end else if (ctl.step && cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (ctl.step && cnt_r != 6'd0) begin
      dvd_r <= {dvd_r[30:0], ~neg};
      rem_r <= neg ? {rem_r[15:0], dvd_r[31]} : trial[16:0];
    end
  end

  assign stat.more      = cnt_r > 6'd1;
  assign stat.quotient  = dvd_r;
  assign stat.remainder = rem_r;

endmodule

// ----- hdl/tcp_ack_congestion_update.sv -----
`timescale 1ns / 1ps
// Sender-side ack processing and congestion window for one connection. Each
// input beat is one event (ack received, data queued, segment sent, open) and
// gives exactly one result beat with the state after the event. Work runs
// under a small microprogram over one shared datapath, one item at a time:
// in_ready is high whenever reset is released and no item is in progress, even
// while a result waits in the output register. Queue, send, open and any ack
// that is not new skip the divider. A new ack runs the bit-serial divider for
// the ring offset wrap and, outside slow start, once more for mss*mss/cwnd.
// Config writes take effect at once and belong in idle time.
module tcp_ack_congestion_update
  import tacu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic        in_synchronized,
  input  logic        in_ack_flag,
  input  logic [31:0] in_ack_number,
  input  logic [15:0] in_peer_window,
  input  logic [15:0] in_length,
  input  logic        in_time_segment,
  // result out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_ack_kind,
  output logic [15:0] out_acked_bytes,
  output logic [15:0] out_congestion_window,
  output logic [7:0]  out_duplicate_count,
  output logic [15:0] out_buffer_start,
  output logic [15:0] out_buffer_length,
  output logic        out_rtt_sample_due,
  output logic [1:0]  out_timer_action
);

  // config registers
  logic [15:0] mss_r, ssthresh_r, buf_size_r;

  // latched input beat
  logic [1:0]  opcode_r;
  logic        sync_r, ackf_r, timed_r;
  logic [31:0] ackn_r;
  logic [15:0] pwin_r, len_r;

  // connection state
  logic [31:0] una_r, nxt_r, rtt_target_r;
  logic [15:0] rwnd_r, cwnd_r, ring_start_r, ring_fill_r;
  logic [7:0]  dup_r;
  logic        rtt_pending_r;

  // per-item scratch
  ack_kind_t   kind_r;
  tmr_t        timer_r;
  logic        sample_r;
  logic [31:0] diff_r, mult_r, adj_r;
  logic [15:0] acked_r;

  // sequencer
  logic        busy_r;
  logic [3:0]  step_r;
  uword_t      uw;
  logic        stall, run, jump, accept;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_kind_r, out_timer_r;
  logic [15:0] out_acked_r, out_cwnd_r, out_start_r, out_fill_r;
  logic [7:0]  out_dup_r;
  logic        out_sample_r;

  // divider
  div_ctl_t    div_ctl;
  div_stat_t   div_stat;
  logic [31:0] div_dividend;
  logic [16:0] div_divisor;
  logic [5:0]  div_iters;

  // datapath helpers
  logic [31:0] diff_now;
  logic [16:0] ring_mod, ring_sum;
  logic [15:0] fill_max, room, add_len;
  logic [31:0] nxt_sum, adj_eff;
  logic [32:0] grow_sum;
  logic [15:0] grow_sat, grow_cap;
  logic        slow_start;

  assign accept   = in_valid && in_ready;
  // no beat is taken while reset is held
  assign in_ready = !busy_r && rst_n;
  assign uw       = tacu_ucode(step_r);
  // the emit step waits for the result register to free up
  assign stall    = (uw.op == U_EMIT) && out_valid_r && !out_ready;
  assign run      = busy_r && !stall;

  assign slow_start = (cwnd_r < ssthresh_r) || (cwnd_r == 16'd0);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:     jump = 1'b1;
      C_NOT_ACKOP:  jump = opcode_r != OPC_ACK;
      C_NOT_NEW:    jump = kind_r != KIND_NEW;
      C_DIV_BUSY:   jump = div_stat.more;
      C_SLOW_START: jump = slow_start;
      default:      jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (run) begin
      if (uw.last) begin
        busy_r <= 1'b0;
        step_r <= '0;
      end else if (jump) begin
        step_r <= uw.target;
      end else begin
        step_r <= step_r + 4'd1;
      end
    end
  end

  // ring wrap and fill limit; a zero size means the full 16-bit space
  assign ring_mod = (buf_size_r == 16'd0) ? 17'h10000 : {1'b0, buf_size_r};
  assign fill_max = (buf_size_r == 16'd0) ? 16'hFFFF : buf_size_r;
  assign ring_sum = {1'b0, ring_start_r} + {1'b0, acked_r};
  assign room     = fill_max - ring_fill_r;
  assign add_len  = (len_r < room) ? len_r : room;
  assign nxt_sum  = nxt_r + {16'd0, len_r};
  assign diff_now = ackn_r - una_r;

  // window growth: at least one byte, saturate, then cap at the old peer window
  assign adj_eff  = (adj_r == 32'd0) ? 32'd1 : adj_r;
  assign grow_sum = {17'd0, cwnd_r} + {1'b0, adj_eff};
  assign grow_sat = (grow_sum > 33'd65535) ? 16'hFFFF : grow_sum[15:0];
  assign grow_cap = (grow_sat > rwnd_r) ? rwnd_r : grow_sat;

  // divider feeds: ring offset wrap, or mss squared over cwnd
  always_comb begin
    if (uw.op == U_RING_LOAD) begin
      div_dividend = {ring_sum, 15'd0};
      div_divisor  = ring_mod;
      div_iters    = DIV_BITS_RING;
    end else begin
      div_dividend = mult_r;
      div_divisor  = {1'b0, cwnd_r};
      div_iters    = DIV_BITS_WIN;
    end
  end

  assign div_ctl.load = run && (uw.op == U_RING_LOAD || uw.op == U_DIV_LOAD_WIN);
  assign div_ctl.step = run && (uw.op == U_DIV_STEP);

  tacu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .stat     (div_stat)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_r      <= 16'd536;
      ssthresh_r <= 16'hFFFF;
      buf_size_r <= 16'd4096;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MSS:      mss_r      <= cfg_data;
        CFG_SSTHRESH: ssthresh_r <= cfg_data;
        CFG_BUF_SIZE: buf_size_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r <= in_opcode;
      sync_r   <= in_synchronized;
      ackf_r   <= in_ack_flag;
      ackn_r   <= in_ack_number;
      pwin_r   <= in_peer_window;
      len_r    <= in_length;
      timed_r  <= in_time_segment;
    end
  end

  // datapath scratch, cleared per item so non-ack events report zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_NONE;
      timer_r  <= TMR_NONE;
      sample_r <= 1'b0;
      acked_r  <= '0;
    end else if (accept) begin
      kind_r   <= KIND_NONE;
      timer_r  <= TMR_NONE;
      sample_r <= 1'b0;
      acked_r  <= '0;
    end else if (run) begin
      case (uw.op)
        U_CLASSIFY: begin
          if (!(sync_r && ackf_r)) begin
            kind_r <= KIND_NONE;
          end else if (diff_now[31]) begin
            kind_r <= KIND_STALE;
          end else if (diff_now == 32'd0) begin
            kind_r <= KIND_SAME;
          end else begin
            kind_r <= KIND_NEW;
          end
        end
        U_ACKED: begin
          acked_r <= (diff_r < {16'd0, ring_fill_r}) ? diff_r[15:0] : ring_fill_r;
        end
        U_POST: begin
          if ((kind_r == KIND_SAME || kind_r == KIND_NEW) && rtt_pending_r &&
              !seq_before(ackn_r, rtt_target_r)) begin
            sample_r <= 1'b1;
          end
          if (kind_r == KIND_NEW) begin
            timer_r <= (una_r != nxt_r) ? TMR_RESTART : TMR_STOP;
          end
        end
        default: ;
      endcase
    end
  end

  // wide scratch, payload only
  always_ff @(posedge clk) begin
    if (run) begin
      case (uw.op)
        U_CLASSIFY: diff_r <= diff_now;
        U_ACKED:    mult_r <= {16'd0, mss_r} * {16'd0, mss_r};
        U_ADJ_QUO:  adj_r  <= div_stat.quotient;
        U_ADJ_MSS:  adj_r  <= {16'd0, mss_r};
        default:    ;
      endcase
    end
  end

  // connection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      una_r         <= '0;
      nxt_r         <= '0;
      rwnd_r        <= '0;
      cwnd_r        <= '0;
      dup_r         <= '0;
      ring_start_r  <= '0;
      ring_fill_r   <= '0;
      rtt_pending_r <= 1'b0;
      rtt_target_r  <= '0;
    end else if (run) begin
      case (uw.op)
        U_RING_LOAD: begin
          ring_fill_r <= ring_fill_r - acked_r;
          una_r       <= ackn_r;
          dup_r       <= '0;
        end
        U_RING_STORE: ring_start_r <= div_stat.remainder[15:0];
        U_GROW:       cwnd_r       <= grow_cap;
        U_POST: begin
          // duplicate test sees the peer window from before this segment
          if (kind_r == KIND_SAME && len_r == 16'd0 && pwin_r == rwnd_r &&
              dup_r != 8'hFF) begin
            dup_r <= dup_r + 8'd1;
          end
          if (kind_r == KIND_SAME || kind_r == KIND_NEW) begin
            rwnd_r <= pwin_r;
            if (rtt_pending_r && !seq_before(ackn_r, rtt_target_r)) begin
              rtt_pending_r <= 1'b0;
            end
          end
        end
        U_OTHER: begin
          unique case (opc_t'(opcode_r))
            OPC_ACK: ;
            OPC_QUEUE: begin
              if (ring_fill_r < fill_max) begin
                ring_fill_r <= ring_fill_r + add_len;
              end
            end
            OPC_SEND: begin
              nxt_r <= nxt_sum;
              if (timed_r && !rtt_pending_r) begin
                rtt_pending_r <= 1'b1;
                rtt_target_r  <= nxt_sum;
              end
            end
            OPC_OPEN: begin
              una_r         <= ackn_r;
              nxt_r         <= ackn_r;
              rwnd_r        <= pwin_r;
              cwnd_r        <= mss_r;
              dup_r         <= '0;
              ring_start_r  <= '0;
              ring_fill_r   <= '0;
              rtt_pending_r <= 1'b0;
              rtt_target_r  <= '0;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (run && uw.op == U_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run && uw.op == U_EMIT) begin
      out_kind_r   <= kind_r;
      out_acked_r  <= acked_r;
      out_cwnd_r   <= cwnd_r;
      out_dup_r    <= dup_r;
      out_start_r  <= ring_start_r;
      out_fill_r   <= ring_fill_r;
      out_sample_r <= sample_r;
      out_timer_r  <= timer_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_ack_kind          = out_kind_r;
  assign out_acked_bytes       = out_acked_r;
  assign out_congestion_window = out_cwnd_r;
  assign out_duplicate_count   = out_dup_r;
  assign out_buffer_start      = out_start_r;
  assign out_buffer_length     = out_fill_r;
  assign out_rtt_sample_due    = out_sample_r;
  assign out_timer_action      = out_timer_r;

  // sequencer parks at step zero between items
  assert property (@(posedge clk) disable iff (!rst_n) !busy_r |-> step_r == 4'd0)
    else $error("sequencer idle away from entry step");

  // a new result only follows an item in progress
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid_r) |-> $past(busy_r))
    else $error("result beat without an item in progress");

  // timer actions come only from new acks
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_timer_r != TMR_NONE |-> out_kind_r == KIND_NEW)
    else $error("timer action on a non-new ack");

  // rtt sample only on an acceptable ack
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sample_r |-> out_kind_r == KIND_SAME || out_kind_r == KIND_NEW)
    else $error("rtt sample on an ignored or stale ack");

endmodule

// ----- dv/tb_tcp_ack_congestion_update.sv -----
`timescale 1ns / 1ps
module tb_tcp_ack_congestion_update;
  import tacu_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 70;    // covers the slowest new-ack pass

  // one event beat as offered on the input channel
  typedef struct {
    opc_t        opcode;
    logic        synced;
    logic        ack_flag;
    logic [31:0] ack_number;
    logic [15:0] peer_window;
    logic [15:0] seg_len;
    logic        timed;
  } ack_event_t;

  // one result beat
  typedef struct {
    ack_kind_t   kind;
    logic [15:0] acked;
    logic [15:0] cwnd;
    logic [7:0]  dup_cnt;
    logic [15:0] ring_head;
    logic [15:0] ring_fill;
    logic        rtt_due;
    tmr_t        timer;
  } ack_result_t;

  // tracks the connection state, predicts each result and checks it in order
  class cwnd_scoreboard;
    logic [15:0] mss, ssthresh, buf_size;
    logic [31:0] una, snd_nxt, rtt_seq;
    logic [15:0] peer_wnd, cwnd, ring_head, ring_fill;
    logic [7:0]  dups;
    logic        rtt_armed;
    ack_result_t due_results[$];
    int unsigned checked, errors, rtt_samples;
    int unsigned kind_seen[4];
    bit          dup_saturated;

    function new();
      mss = 16'd536;
      ssthresh = 16'd65535;
      buf_size = 16'd4096;
      una = '0;
      snd_nxt = '0;
      rtt_seq = '0;
      peer_wnd = '0;
      cwnd = '0;
      ring_head = '0;
      ring_fill = '0;
      dups = '0;
      rtt_armed = 1'b0;
      checked = 0;
      errors = 0;
      rtt_samples = 0;
      kind_seen = '{default: 0};
      dup_saturated = 1'b0;
    endfunction

    function void set_cfg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_MSS:      mss = val;
        CFG_SSTHRESH: ssthresh = val;
        CFG_BUF_SIZE: buf_size = val;
        default: ;
      endcase
    endfunction

    // advance the connection state by one accepted event
    function void apply_event(ack_event_t ev);
      ack_result_t r;
      logic [31:0] diff, freed, adj, total, ring_mod, fill_max, room, lead;
      r.kind = KIND_NONE;
      r.acked = '0;
      r.rtt_due = 1'b0;
      r.timer = TMR_NONE;
      // zero buffer size means a full 64k ring
      ring_mod = (buf_size == 16'd0) ? 32'd65536 : {16'd0, buf_size};
      fill_max = (buf_size == 16'd0) ? 32'd65535 : {16'd0, buf_size};
      case (ev.opcode)
        OPC_ACK: begin
          if (ev.synced && ev.ack_flag) begin
            diff = ev.ack_number - una;
            if (diff[31]) begin
              r.kind = KIND_STALE;
            end else begin
              if (diff == 32'd0) begin
                r.kind = KIND_SAME;
                if (ev.seg_len == 16'd0 && ev.peer_window == peer_wnd && dups != 8'hFF)
                  dups = dups + 8'd1;
              end else begin
                r.kind = KIND_NEW;
                freed = (diff < {16'd0, ring_fill}) ? diff : {16'd0, ring_fill};
                r.acked = freed[15:0];
                lead = ({16'd0, ring_head} + freed) % ring_mod;
                ring_head = lead[15:0];
                ring_fill = ring_fill - freed[15:0];
                una = ev.ack_number;
                if (cwnd < ssthresh || cwnd == 16'd0)
                  adj = {16'd0, mss};
                else
                  adj = ({16'd0, mss} * {16'd0, mss}) / {16'd0, cwnd};
                if (adj == 32'd0) adj = 32'd1;
                total = {16'd0, cwnd} + adj;
                if (total > 32'd65535) total = 32'd65535;
                // cap uses the window held before this segment
                if (total > {16'd0, peer_wnd}) total = {16'd0, peer_wnd};
                cwnd = total[15:0];
                dups = 8'd0;
              end
              peer_wnd = ev.peer_window;
              lead = ev.ack_number - rtt_seq;
              if (rtt_armed && !lead[31]) begin
                rtt_armed = 1'b0;
                r.rtt_due = 1'b1;
                rtt_samples++;
              end
              if (diff != 32'd0) r.timer = (una != snd_nxt) ? TMR_RESTART : TMR_STOP;
            end
          end
          kind_seen[r.kind]++;
        end
        OPC_QUEUE: begin
          if ({16'd0, ring_fill} < fill_max) begin
            room = fill_max - {16'd0, ring_fill};
            ring_fill = ring_fill + (({16'd0, ev.seg_len} < room) ? ev.seg_len : room[15:0]);
          end
        end
        OPC_SEND: begin
          snd_nxt = snd_nxt + {16'd0, ev.seg_len};
          if (ev.timed && !rtt_armed) begin
            rtt_armed = 1'b1;
            rtt_seq = snd_nxt;
          end
        end
        default: begin
          una = ev.ack_number;
          snd_nxt = ev.ack_number;
          peer_wnd = ev.peer_window;
          cwnd = mss;
          dups = '0;
          ring_head = '0;
          ring_fill = '0;
          rtt_armed = 1'b0;
          rtt_seq = '0;
        end
      endcase
      if (dups == 8'hFF) dup_saturated = 1'b1;
      r.cwnd = cwnd;
      r.dup_cnt = dups;
      r.ring_head = ring_head;
      r.ring_fill = ring_fill;
      due_results.push_back(r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 25)
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", checked, field, got, want);
    endtask

    task check_result(ack_result_t got);
      ack_result_t want;
      checked++;
      if (due_results.size() == 0) begin
        report("result with nothing outstanding", 32'd0, 32'd0);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind)
        report("ack_kind", 32'(got.kind), 32'(want.kind));
      if (got.acked !== want.acked)
        report("acked_bytes", 32'(got.acked), 32'(want.acked));
      if (got.cwnd !== want.cwnd)
        report("congestion_window", 32'(got.cwnd), 32'(want.cwnd));
      if (got.dup_cnt !== want.dup_cnt)
        report("duplicate_count", 32'(got.dup_cnt), 32'(want.dup_cnt));
      if (got.ring_head !== want.ring_head)
        report("buffer_start", 32'(got.ring_head), 32'(want.ring_head));
      if (got.ring_fill !== want.ring_fill)
        report("buffer_length", 32'(got.ring_fill), 32'(want.ring_fill));
      if (got.rtt_due !== want.rtt_due)
        report("rtt_sample_due", 32'(got.rtt_due), 32'(want.rtt_due));
      if (got.timer !== want.timer)
        report("timer_action", 32'(got.timer), 32'(want.timer));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic        in_synchronized;
  logic        in_ack_flag;
  logic [31:0] in_ack_number;
  logic [15:0] in_peer_window;
  logic [15:0] in_length;
  logic        in_time_segment;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_ack_kind;
  logic [15:0] out_acked_bytes;
  logic [15:0] out_congestion_window;
  logic [7:0]  out_duplicate_count;
  logic [15:0] out_buffer_start;
  logic [15:0] out_buffer_length;
  logic        out_rtt_sample_due;
  logic [1:0]  out_timer_action;

  cwnd_scoreboard sb;
  ack_result_t    result_beat;
  int unsigned    cycle_count;
  int unsigned    events_sent;
  bit             idle_on;    // random stalls allowed on both sides
  bit             hold_req;   // ask the receiver for one long hold-off

  tcp_ack_congestion_update u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_opcode             (in_opcode),
    .in_synchronized       (in_synchronized),
    .in_ack_flag           (in_ack_flag),
    .in_ack_number         (in_ack_number),
    .in_peer_window        (in_peer_window),
    .in_length             (in_length),
    .in_time_segment       (in_time_segment),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_ack_kind          (out_ack_kind),
    .out_acked_bytes       (out_acked_bytes),
    .out_congestion_window (out_congestion_window),
    .out_duplicate_count   (out_duplicate_count),
    .out_buffer_start      (out_buffer_start),
    .out_buffer_length     (out_buffer_length),
    .out_rtt_sample_due    (out_rtt_sample_due),
    .out_timer_action      (out_timer_action)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result beats are checked at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      result_beat.kind      = ack_kind_t'(out_ack_kind);
      result_beat.acked     = out_acked_bytes;
      result_beat.cwnd      = out_congestion_window;
      result_beat.dup_cnt   = out_duplicate_count;
      result_beat.ring_head = out_buffer_start;
      result_beat.ring_fill = out_buffer_length;
      result_beat.rtt_due   = out_rtt_sample_due;
      result_beat.timer     = tmr_t'(out_timer_action);
      sb.check_result(result_beat);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic ack_event_t build(opc_t op, logic sync, logic flag, logic [31:0] num,
                                       logic [15:0] win, logic [15:0] len, logic timed);
    ack_event_t ev;
    ev.opcode      = op;
    ev.synced      = sync;
    ev.ack_flag    = flag;
    ev.ack_number  = num;
    ev.peer_window = win;
    ev.seg_len     = len;
    ev.timed       = timed;
    return ev;
  endfunction

  // offer one beat and hold it until taken; the state is updated at the taking edge
  task automatic send_item(ack_event_t ev);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_opcode       <= ev.opcode;
    in_synchronized <= ev.synced;
    in_ack_flag     <= ev.ack_flag;
    in_ack_number   <= ev.ack_number;
    in_peer_window  <= ev.peer_window;
    in_length       <= ev.seg_len;
    in_time_segment <= ev.timed;
    do begin
      @(posedge clk);
    end while (in_ready !== 1'b1);
    sb.apply_event(ev);
    events_sent++;
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    sb.set_cfg(idx, val);
  endtask

  task automatic apply_setting(logic [15:0] seg_size, logic [15:0] thresh, logic [15:0] ring);
    write_reg(CFG_MSS, seg_size);
    write_reg(CFG_SSTHRESH, thresh);
    write_reg(CFG_BUF_SIZE, ring);
  endtask

  task automatic open_connection();
    send_item(build(OPC_OPEN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
                    16'($urandom_range(2000, 65535)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1))));
  endtask

  task automatic run_directed();
    // ack before any open matches una of zero and counts as a duplicate
    send_item(build(OPC_ACK, 1'b1, 1'b1, 32'd0, 16'd0, 16'd0, 1'b0));
    // not synchronized: ignored
    send_item(build(OPC_ACK, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // open just below the sequence wrap
    send_item(build(OPC_OPEN, 1'b0, 1'b0, 32'hFFFF_FF00, 16'hFFFF, 16'd0, 1'b0));
    // overfill the ring, then queue into a full ring
    send_item(build(OPC_QUEUE, 1'b0, 1'b0, 32'd0, 16'd0, 16'hFFFF, 1'b0));
    send_item(build(OPC_QUEUE, 1'b0, 1'b0, 32'd0, 16'd0, 16'd1, 1'b1));
    // timed send across the wrap, then a timed send while one is pending
    send_item(build(OPC_SEND, 1'b0, 1'b0, 32'd0, 16'd0, 16'd1000, 1'b1));
    send_item(build(OPC_SEND, 1'b0, 1'b0, 32'd0, 16'd0, 16'd3000, 1'b1));
    // ack bit clear: ignored
    send_item(build(OPC_ACK, 1'b1, 1'b0, sb.una + 32'd10, 16'd100, 16'd0, 1'b0));
    // stale by one, and by exactly half the sequence space
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una - 32'd1, 16'hFFFF, 16'd0, 1'b0));
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una + 32'h8000_0000, 16'hFFFF, 16'd0, 1'b0));
    // equal ack with data, with a new window, then true duplicates
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una, 16'hFFFF, 16'd5, 1'b0));
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una, 16'd8000, 16'd0, 1'b0));
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una, 16'd8000, 16'd0, 1'b0));
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una, 16'd8000, 16'd0, 1'b0));
    // partial new ack, then up to the timed segment while the window closes
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una + 32'd200, 16'd8000, 16'd0, 1'b0));
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.rtt_seq, 16'd0, 16'd0, 1'b0));
    // everything acked: timer stops, window capped to zero
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.snd_nxt, 16'hFFFF, 16'd0, 1'b0));
    // zero-length timed send, sampled by an equal ack
    send_item(build(OPC_SEND, 1'b0, 1'b0, 32'd0, 16'd0, 16'd0, 1'b1));
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una, 16'hFFFF, 16'd0, 1'b0));
    // far-ahead ack frees more than the ring holds
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una + 32'h7FFF_FFFF, 16'hFFFF, 16'd0, 1'b0));
    send_item(build(OPC_OPEN, 1'b1, 1'b1, 32'd0, 16'd0, 16'hFFFF, 1'b1));
  endtask

  // cwnd forced to zero outside slow start, then grown by a full mss and capped at the peer window
  task automatic zero_window_probe();
    send_item(build(OPC_OPEN, 1'b0, 1'b0, $urandom(), 16'd0, 16'd0, 1'b0));
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una + 32'd10, 16'd40000, 16'd0, 1'b0));
    send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una + 32'd10, 16'd40000, 16'd0, 1'b0));
  endtask

  // long run of duplicates to reach the saturation point
  task automatic dup_storm(int n);
    for (int i = 0; i < n; i++)
      send_item(build(OPC_ACK, 1'b1, 1'b1, sb.una, sb.peer_wnd, 16'd0,
                      1'($urandom_range(0, 1))));
  endtask

  // mostly well-formed traffic for the open connection, some broken and random beats
  task automatic run_traffic(int n, bit gaps);
    ack_event_t  ev;
    int          pick;
    bit          quiet;
    logic [31:0] span, num;
    logic [15:0] win, len;
    quiet = 1'b0;
    for (int i = 0; i < n; i++) begin
      // stretches with no idling at all
      if (i % 48 == 0) quiet = ($urandom_range(0, 2) == 0);
      idle_on = gaps && !quiet;
      span = sb.snd_nxt - sb.una;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        ev = build(OPC_OPEN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
                   16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
      end else if (pick < 18) begin
        len = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3000));
        ev = build(OPC_QUEUE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
                   16'($urandom_range(0, 65535)), len, 1'($urandom_range(0, 1)));
      end else if (pick < 36) begin
        len = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 2000));
        ev = build(OPC_SEND, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
                   16'($urandom_range(0, 65535)), len, $urandom_range(0, 2) == 0);
      end else if (pick < 68) begin
        // new ack: inside the flight, at its end, or beyond it
        if (span != 32'd0 && !span[31])
          num = ($urandom_range(0, 3) == 0) ? sb.snd_nxt : sb.una + $urandom_range(1, span);
        else
          num = sb.una + $urandom_range(1, 4000);
        if ($urandom_range(0, 7) == 0) num = sb.snd_nxt + $urandom_range(1, 3000);
        case ($urandom_range(0, 3))
          0:       win = sb.peer_wnd;
          1:       win = 16'($urandom_range(0, 65535));
          default: win = 16'($urandom_range(30000, 65535));
        endcase
        len = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 1500));
        ev = build(OPC_ACK, 1'b1, 1'b1, num, win, len, 1'($urandom_range(0, 1)));
      end else if (pick < 78) begin
        win = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) : sb.peer_wnd;
        ev = build(OPC_ACK, 1'b1, 1'b1, sb.una, win, 16'd0, 1'($urandom_range(0, 1)));
      end else if (pick < 84) begin
        num = ($urandom_range(0, 5) == 0) ? sb.una + 32'h8000_0000
                                          : sb.una - $urandom_range(1, 100000);
        ev = build(OPC_ACK, 1'b1, 1'b1, num, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        // ignored: synchronized or ack flag low
        case ($urandom_range(0, 2))
          0:       ev = build(OPC_ACK, 1'b0, 1'b1, sb.una + 32'd1, 16'hFFFF, 16'd0, 1'b0);
          1:       ev = build(OPC_ACK, 1'b1, 1'b0, $urandom(), 16'd0, 16'd0, 1'b1);
          default: ev = build(OPC_ACK, 1'b0, 1'b0, $urandom(), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        endcase
      end else begin
        ev = build(opc_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom(), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
      send_item(ev);
      if (idle_on && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 17));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = CFG_MSS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_opcode = OPC_ACK;
    in_synchronized = 1'b0;
    in_ack_flag = 1'b0;
    in_ack_number = '0;
    in_peer_window = '0;
    in_length = '0;
    in_time_segment = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    cycle_count = 0;
    events_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of the registers
    run_directed();
    settle();

    // typical ethernet-sized setting, with the long receiver hold-off
    apply_setting(16'd1460, 16'd4380, 16'd16384);
    open_connection();
    run_traffic(10, 1'b1);
    hold_req = 1'b1;
    run_traffic(40, 1'b0);
    run_traffic(144, 1'b1);
    settle();

    // everything at max, threshold zero: window overflow and cap
    apply_setting(16'd65535, 16'd0, 16'd65535);
    zero_window_probe();
    open_connection();
    run_traffic(191, 1'b1);
    settle();

    // smallest legal values: growth floors at one byte
    apply_setting(16'd1, 16'd0, 16'd1);
    open_connection();
    dup_storm(260);
    run_traffic(194, 1'b1);
    settle();

    // zero mss and zero ring size
    apply_setting(16'd0, 16'd65535, 16'd0);
    open_connection();
    run_traffic(194, 1'b1);
    settle();

    apply_setting(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
    open_connection();
    run_traffic(194, 1'b1);
    settle();

    // back to reset values, no idling at the end
    apply_setting(16'd536, 16'd65535, 16'd4096);
    open_connection();
    run_traffic(194, 1'b0);
    settle();

    $display("%0d events, %0d results; acks new %0d, equal %0d, stale %0d, ignored %0d",
             events_sent, sb.checked, sb.kind_seen[KIND_NEW], sb.kind_seen[KIND_SAME],
             sb.kind_seen[KIND_STALE], sb.kind_seen[KIND_NONE]);
    $display("%0d rtt samples, duplicate count saturated: %0d, mismatches: %0d",
             sb.rtt_samples, sb.dup_saturated, sb.errors);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tacu_pkg.sv
hdl/tacu_div.sv
hdl/tcp_ack_congestion_update.sv
dv/tb_tcp_ack_congestion_update.sv
